FILE: rtl/wtmt_pkg.sv
// Shared types, codes and defaults for the wildcard triple match table.
package wtmt_pkg;

    // Port field widths (fixed by the interface).
    localparam int KEY_W      = 32;
    localparam int RANK_W     = 6;
    localparam int SLOT_OUT_W = 6;
    localparam int KIND_W     = 2;
    localparam int STATUS_W   = 2;

    // Defaults for the top level parameters.
    localparam int TABLE_DEPTH_DEFAULT = 64;
    localparam int KEY_BITS_DEFAULT    = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_MATCH  = 2'd1,
        KIND_DELETE = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE     = 2'd0,
        STATUS_NO_MATCH = 2'd1,
        STATUS_FULL     = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN
    } state_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  subject_key;
        logic [KEY_W-1:0]  predicate_key;
        logic [KEY_W-1:0]  object_key;
        logic [RANK_W-1:0] match_rank;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [KEY_W-1:0]      found_subject;
        logic [KEY_W-1:0]      found_predicate;
        logic [KEY_W-1:0]      found_object;
        logic [SLOT_OUT_W-1:0] slot_index;
    } out_item_t;

endpackage

FILE: rtl/wtmt_ram.sv
// Generic single write port, single read port RAM with registered read data.
module wtmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/wildcard_triple_match_table_core.sv
// Wildcard triple match table: a RAM of subject/predicate/object slots scanned one slot a cycle.
//
// Each slot holds three KEY_BITS-bit keys and a valid mark, all in one RAM row.
// Insert writes the lowest slot whose mark is clear; match and delete walk the
// slots in ascending order, count the valid rows that agree on every nonzero
// query key and act on the one whose count equals match_rank. Input keys are
// cut to their low KEY_BITS bits; result keys are the low 32 bits of the stored
// ones and slot_index is the low 6 bits of the slot. After reset a clearing pass
// writes every row once, with s_ready low. An item is taken in while idle
// and then scanned in ascending slot order, paced by the single RAM read port,
// which the sequencer steps through one slot per cycle. An insert stops at the
// first free slot, and an unknown kind scans the whole table before answering
// no match. The result sits in an output register; the scan of the next item
// may start while it waits, and only the final transfer of that item waits for
// it to drain.
module wildcard_triple_match_table_core #(
    parameter int TABLE_DEPTH = wtmt_pkg::TABLE_DEPTH_DEFAULT,
    parameter int KEY_BITS    = wtmt_pkg::KEY_BITS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wtmt_pkg::in_item_t  s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output wtmt_pkg::out_item_t m_item
);

    localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int ROW_W  = 3 * KEY_BITS + 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);

    wtmt_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0]             slot_reg, slot_next;
    logic [wtmt_pkg::RANK_W-1:0]   rank_reg, rank_next;
    logic [wtmt_pkg::KIND_W-1:0]   kind_reg, kind_next;
    logic [KEY_BITS-1:0]           qs_reg, qs_next;
    logic [KEY_BITS-1:0]           qp_reg, qp_next;
    logic [KEY_BITS-1:0]           qo_reg, qo_next;
    logic                          m_valid_reg, m_valid_next;
    wtmt_pkg::out_item_t           m_item_reg, m_item_next;

    // RAM ports
    logic              ram_we;
    logic [SLOT_W-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [SLOT_W-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    // Width adaptation of keys and slot
    logic [KEY_BITS+wtmt_pkg::KEY_W-1:0] s_ext, p_ext, o_ext;
    logic [KEY_BITS+wtmt_pkg::KEY_W-1:0] fs_ext, fp_ext, fo_ext;
    logic [SLOT_W+wtmt_pkg::SLOT_OUT_W-1:0] slot_ext;

    // Row fields and scan decisions
    logic                row_valid;
    logic [KEY_BITS-1:0] row_s, row_p, row_o;
    logic                agree, is_insert, is_find;
    logic                free_hit, row_match, rank_hit, last_slot, finish, out_free;
    logic                load_result;

    wtmt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (TABLE_DEPTH)
    ) u_slots (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ext = {{KEY_BITS{1'b0}}, s_item.subject_key};
    assign p_ext = {{KEY_BITS{1'b0}}, s_item.predicate_key};
    assign o_ext = {{KEY_BITS{1'b0}}, s_item.object_key};

    assign row_valid = ram_rdata[ROW_W-1];
    assign row_s     = ram_rdata[3*KEY_BITS-1:2*KEY_BITS];
    assign row_p     = ram_rdata[2*KEY_BITS-1:KEY_BITS];
    assign row_o     = ram_rdata[KEY_BITS-1:0];

    // Zero query key is a wildcard
    assign agree = ((qs_reg == '0) || (row_s == qs_reg))
                && ((qp_reg == '0) || (row_p == qp_reg))
                && ((qo_reg == '0) || (row_o == qo_reg));

    assign is_insert = (kind_reg == wtmt_pkg::KIND_INSERT);
    assign is_find   = (kind_reg == wtmt_pkg::KIND_MATCH)
                    || (kind_reg == wtmt_pkg::KIND_DELETE);
    assign free_hit  = is_insert && !row_valid;
    assign row_match = is_find && row_valid && agree;
    assign rank_hit  = row_match && (rank_reg == '0);
    assign last_slot = (slot_reg == LAST_SLOT);
    assign finish    = free_hit || rank_hit || last_slot;
    assign out_free  = !m_valid_reg || m_ready;
    assign load_result = (state_reg == wtmt_pkg::ST_SCAN) && finish && out_free;

    // Insert reports the query keys, a find the stored ones
    assign fs_ext   = {{wtmt_pkg::KEY_W{1'b0}}, (free_hit ? qs_reg : row_s)};
    assign fp_ext   = {{wtmt_pkg::KEY_W{1'b0}}, (free_hit ? qp_reg : row_p)};
    assign fo_ext   = {{wtmt_pkg::KEY_W{1'b0}}, (free_hit ? qo_reg : row_o)};
    assign slot_ext = {{wtmt_pkg::SLOT_OUT_W{1'b0}}, slot_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wtmt_pkg::ST_CLEAR;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers, no reset needed
    always_ff @(posedge aclk) begin
        rank_reg   <= rank_next;
        kind_reg   <= kind_next;
        qs_reg     <= qs_next;
        qp_reg     <= qp_next;
        qo_reg     <= qo_next;
        m_item_reg <= m_item_next;
    end

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        rank_next    = rank_reg;
        kind_next    = kind_reg;
        qs_next      = qs_reg;
        qp_next      = qp_reg;
        qo_next      = qo_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_item_next  = m_item_reg;
        s_ready      = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = slot_reg;
        ram_wdata    = '0;
        ram_raddr    = '0;

        case (state_reg)
            wtmt_pkg::ST_CLEAR: begin
                // One row per cycle, valid mark cleared
                ram_we = 1'b1;
                if (last_slot) begin
                    slot_next  = '0;
                    state_next = wtmt_pkg::ST_IDLE;
                end else begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            wtmt_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = '0;
                if (s_valid) begin
                    kind_next  = s_item.kind;
                    qs_next    = s_ext[KEY_BITS-1:0];
                    qp_next    = p_ext[KEY_BITS-1:0];
                    qo_next    = o_ext[KEY_BITS-1:0];
                    rank_next  = s_item.match_rank;
                    slot_next  = '0;
                    state_next = wtmt_pkg::ST_SCAN;
                end
            end
            wtmt_pkg::ST_SCAN: begin
                // Read data belongs to slot_reg; fetch the next slot ahead
                if (finish) begin
                    ram_raddr = slot_reg;
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        if (free_hit || rank_hit) begin
                            m_item_next.status          = wtmt_pkg::STATUS_DONE;
                            m_item_next.found_subject   = fs_ext[wtmt_pkg::KEY_W-1:0];
                            m_item_next.found_predicate = fp_ext[wtmt_pkg::KEY_W-1:0];
                            m_item_next.found_object    = fo_ext[wtmt_pkg::KEY_W-1:0];
                            m_item_next.slot_index      =
                                slot_ext[wtmt_pkg::SLOT_OUT_W-1:0];
                        end else begin
                            m_item_next = '0;
                            m_item_next.status = is_insert ? wtmt_pkg::STATUS_FULL
                                                           : wtmt_pkg::STATUS_NO_MATCH;
                        end
                        if (free_hit) begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, qs_reg, qp_reg, qo_reg};
                        end else if (rank_hit
                                     && (kind_reg == wtmt_pkg::KIND_DELETE)) begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b0, row_s, row_p, row_o};
                        end
                        slot_next  = '0;
                        state_next = wtmt_pkg::ST_IDLE;
                    end
                end else begin
                    ram_raddr = slot_reg + SLOT_W'(1);
                    slot_next = slot_reg + SLOT_W'(1);
                    if (row_match) begin
                        rank_next = rank_reg - wtmt_pkg::RANK_W'(1);
                    end
                end
            end
            default: begin
                state_next = wtmt_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // The RAM is written only by the clearing pass or at the close of a scan
    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == wtmt_pkg::ST_CLEAR) || load_result)
        else $error("slot RAM written outside clear pass or scan close");

    // A taken item always starts a scan on the next cycle
    a_accept_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == wtmt_pkg::ST_SCAN))
        else $error("accepted transfer did not start a scan");

    // A failed operation carries all-zero keys and slot
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_item_reg.status != wtmt_pkg::STATUS_DONE))
        |-> (m_item_reg.slot_index == '0) && (m_item_reg.found_subject == '0)
            && (m_item_reg.found_predicate == '0) && (m_item_reg.found_object == '0))
        else $error("failed result carries nonzero fields");

    // A new result is never loaded over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !load_result)
        else $error("result loaded over a pending transfer");

endmodule
